// ----- rtl/tpi_pkg.sv -----
`default_nettype none

package tpi_pkg;

    localparam int SLOT_BITS     = 16;
    localparam int VERTEX_BITS   = 3 * SLOT_BITS;
    localparam int MUL_CHUNK_LOG = 3;
    localparam int MUL_CHUNK     = 1 << MUL_CHUNK_LOG;

    // cycles through tpi_mul for a chunked operand of wb bits
    function automatic int mul_latency(input int wb);
        return ((wb + MUL_CHUNK - 1) >> MUL_CHUNK_LOG) + 2;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tpi_mul.sv -----
`default_nettype none

module tpi_mul #(
    parameter int WA = 16,
    parameter int WB = 16
) (
    input  logic                     clk,
    input  logic signed [WA-1:0]     a,
    input  logic signed [WB-1:0]     b,
    output logic signed [WA+WB-1:0]  p
);

    localparam int CW  = tpi_pkg::MUL_CHUNK;
    localparam int NCH = (WB + CW - 1) / CW;
    localparam int BPW = NCH * CW;
    localparam int PW  = WA + WB;
    localparam int QW  = WA + CW;

    logic [WA-1:0]  a_u;
    logic [WB-1:0]  b_u;
    logic [WA-1:0]  a_abs;
    logic [WB-1:0]  b_abs;

    logic [WA-1:0]  amag_reg [NCH];
    logic [BPW-1:0] bmag_reg [NCH];
    logic           neg_reg  [NCH+1];
    logic [PW-1:0]  acc_reg  [NCH];
    logic [PW-1:0]  p_reg;

    assign a_u   = a;
    assign b_u   = b;
    assign a_abs = a_u[WA-1] ? (~a_u + 1'b1) : a_u;
    assign b_abs = b_u[WB-1] ? (~b_u + 1'b1) : b_u;

    // magnitudes in, sign kept aside
    always_ff @(posedge clk)
    begin
        amag_reg[0] <= a_abs;
        bmag_reg[0] <= BPW'(b_abs);
        neg_reg[0]  <= a_u[WA-1] ^ b_u[WB-1];
    end

    // one chunk of b per stage
    for (genvar k = 0; k < NCH; k++) begin : g_chunk
        logic [QW-1:0] prod;
        logic [PW-1:0] part;

        assign prod = QW'(amag_reg[k]) * QW'(bmag_reg[k][k*CW +: CW]);
        assign part = PW'(prod) << (k * CW);

        if (k == 0) begin : g_first
            always_ff @(posedge clk)
            begin
                acc_reg[0] <= part;
            end
        end else begin : g_rest
            always_ff @(posedge clk)
            begin
                acc_reg[k] <= acc_reg[k-1] + part;
            end
        end

        if (k < NCH - 1) begin : g_pass
            always_ff @(posedge clk)
            begin
                amag_reg[k+1] <= amag_reg[k];
                bmag_reg[k+1] <= bmag_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[k+1] <= neg_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= neg_reg[NCH] ? (~acc_reg[NCH-1] + 1'b1) : acc_reg[NCH-1];
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- rtl/triangle_pair_intersect_test.sv -----
// Triangle pair crossing test, fully pipelined: one pair of triangles may be started in every
// cycle and busy stays low. The answer for a pair appears with a one-cycle done strobe after
// six stages of edges, normals, distances and projections, a bank of wide multipliers that
// forms the segment end points, an end point stage, a second bank for the exact rational
// compares of the end points and a final overlap stage. Both banks take their narrow
// operand eight bits per stage. Results come out in start order and the receiver cannot
// stall them. Touching contact, coplanar and degenerate triangles are misses; both
// straddle flags are reported for every pair.
`default_nettype none

module triangle_pair_intersect_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [tpi_pkg::VERTEX_BITS-1:0]    a_vertex_0,
    input  logic [tpi_pkg::VERTEX_BITS-1:0]    a_vertex_1,
    input  logic [tpi_pkg::VERTEX_BITS-1:0]    a_vertex_2,
    input  logic [tpi_pkg::VERTEX_BITS-1:0]    b_vertex_0,
    input  logic [tpi_pkg::VERTEX_BITS-1:0]    b_vertex_1,
    input  logic [tpi_pkg::VERTEX_BITS-1:0]    b_vertex_2,
    output logic                               done,
    output logic                               hit,
    output logic                               a_straddles_b_plane,
    output logic                               b_straddles_a_plane
);

    localparam int S    = tpi_pkg::SLOT_BITS;
    localparam int C    = COORD_BITS;
    localparam int E    = C + 1;
    localparam int NW   = 2 * E + 1;
    localparam int DPW  = 2 * NW;
    localparam int DIRW = DPW + 1;
    localparam int DDW  = NW + E;
    localparam int DW   = DDW + 2;
    localparam int APW  = DIRW + E;
    localparam int AW   = APW + 2;
    localparam int P1W  = AW + DW;
    localparam int NUMW = P1W + 1;
    localparam int DENW = DW + 1;
    localparam int PRW  = NUMW + DENW;
    localparam int L1   = tpi_pkg::mul_latency(DW);
    localparam int L2   = tpi_pkg::mul_latency(DENW);
    localparam int LAT  = L1 + L2 + 8;
    localparam int B1W  = 6 * DW + 4;

    localparam int IX1 [3] = '{1, 2, 0};
    localparam int IX2 [3] = '{2, 0, 1};

    logic [tpi_pkg::VERTEX_BITS-1:0] va [3];
    logic [tpi_pkg::VERTEX_BITS-1:0] vb [3];
    logic signed [C-1:0]  ca [3][3];
    logic signed [C-1:0]  cb [3][3];
    logic                 accept;
    logic [LAT-1:0]       vld_reg;

    assign va[0] = a_vertex_0;
    assign va[1] = a_vertex_1;
    assign va[2] = a_vertex_2;
    assign vb[0] = b_vertex_0;
    assign vb[1] = b_vertex_1;
    assign vb[2] = b_vertex_2;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ca[i][j] = va[i][j*S +: C];
                cb[i][j] = vb[i][j*S +: C];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    // stage 1: edges and offsets
    logic signed [E-1:0] ea_reg [2][3];
    logic signed [E-1:0] eb_reg [2][3];
    logic signed [E-1:0] qa_reg [3][3];
    logic signed [E-1:0] qb_reg [3][3];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                ea_reg[i][j] <= E'(ca[i+1][j]) - E'(ca[0][j]);
                eb_reg[i][j] <= E'(cb[i+1][j]) - E'(cb[0][j]);
            end
            for (int i = 0; i < 3; i++)
            begin
                qa_reg[i][j] <= E'(ca[i][j]) - E'(cb[0][j]);
                qb_reg[i][j] <= E'(cb[i][j]) - E'(ca[0][j]);
            end
        end
    end

    // stage 2: plane normals
    logic signed [NW-1:0] na_reg [3];
    logic signed [NW-1:0] nb_reg [3];
    logic signed [E-1:0]  qa2_reg [3][3];
    logic signed [E-1:0]  qb2_reg [3][3];
    logic signed [E-1:0]  pa2_reg [2][3];

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            na_reg[c] <= NW'(ea_reg[0][IX1[c]]) * NW'(ea_reg[1][IX2[c]])
                       - NW'(ea_reg[0][IX2[c]]) * NW'(ea_reg[1][IX1[c]]);
            nb_reg[c] <= NW'(eb_reg[0][IX1[c]]) * NW'(eb_reg[1][IX2[c]])
                       - NW'(eb_reg[0][IX2[c]]) * NW'(eb_reg[1][IX1[c]]);
        end
        qa2_reg <= qa_reg;
        qb2_reg <= qb_reg;
        pa2_reg <= ea_reg;
    end

    // stage 3: products for line direction and plane distances
    logic signed [DPW-1:0] dirp_reg [3][2];
    logic signed [DDW-1:0] dap_reg  [3][3];
    logic signed [DDW-1:0] dbp_reg  [3][3];
    logic signed [E-1:0]   qb3_reg  [3][3];
    logic signed [E-1:0]   pa3_reg  [2][3];

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            dirp_reg[c][0] <= DPW'(na_reg[IX1[c]]) * DPW'(nb_reg[IX2[c]]);
            dirp_reg[c][1] <= DPW'(na_reg[IX2[c]]) * DPW'(nb_reg[IX1[c]]);
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                dap_reg[i][j] <= DDW'(nb_reg[j]) * DDW'(qa2_reg[i][j]);
                dbp_reg[i][j] <= DDW'(na_reg[j]) * DDW'(qb2_reg[i][j]);
            end
        end
        qb3_reg <= qb2_reg;
        pa3_reg <= pa2_reg;
    end

    // stage 4: direction and distances; triangle 0 is a, 1 is b
    logic signed [DIRW-1:0] dir_reg [3];
    logic signed [DW-1:0]   dd_reg  [2][3];
    logic signed [E-1:0]    qb4_reg [3][3];
    logic signed [E-1:0]    pa4_reg [2][3];

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            dir_reg[c] <= DIRW'(dirp_reg[c][0]) - DIRW'(dirp_reg[c][1]);
        end
        for (int i = 0; i < 3; i++)
        begin
            dd_reg[0][i] <= DW'(dap_reg[i][0]) + DW'(dap_reg[i][1]) + DW'(dap_reg[i][2]);
            dd_reg[1][i] <= DW'(dbp_reg[i][0]) + DW'(dbp_reg[i][1]) + DW'(dbp_reg[i][2]);
        end
        qb4_reg <= qb3_reg;
        pa4_reg <= pa3_reg;
    end

    // stage 5: projection products, odd vertex per triangle
    logic [2:0] pos_m [2];
    logic [2:0] neg_m [2];
    logic [2:0] odd_m [2];
    logic [1:0] one_pos;
    logic [1:0] strad5;

    logic signed [APW-1:0] apr_reg [2][3];
    logic signed [APW-1:0] bpr_reg [3][3];
    logic signed [DW-1:0]  dd5_reg [2][3];
    logic [1:0]            osel5_reg [2];
    logic [1:0]            opos5_reg;
    logic [1:0]            strad5_reg;

    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg_m[t][i] = dd_reg[t][i][DW-1];
                pos_m[t][i] = !dd_reg[t][i][DW-1] && (dd_reg[t][i] != '0);
            end
            one_pos[t] = ((pos_m[t] & (pos_m[t] - 3'd1)) == 3'd0) && (|pos_m[t]);
            strad5[t]  = (|pos_m[t]) && (|neg_m[t]);
            odd_m[t]   = one_pos[t] ? pos_m[t] : neg_m[t];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                apr_reg[i][j] <= APW'(dir_reg[j]) * APW'(pa4_reg[i][j]);
            end
            for (int i = 0; i < 3; i++)
            begin
                bpr_reg[i][j] <= APW'(dir_reg[j]) * APW'(qb4_reg[i][j]);
            end
        end
        for (int t = 0; t < 2; t++)
        begin
            osel5_reg[t] <= odd_m[t][1] ? 2'd1 : (odd_m[t][2] ? 2'd2 : 2'd0);
        end
        dd5_reg    <= dd_reg;
        opos5_reg  <= one_pos;
        strad5_reg <= strad5;
    end

    // stage 6: projections, operand select
    logic signed [AW-1:0] aval [2][3];
    logic [1:0]           xsel [2];
    logic [1:0]           ysel [2];

    logic signed [AW-1:0] ao6_reg  [2];
    logic signed [AW-1:0] ax6_reg  [2];
    logic signed [AW-1:0] ay6_reg  [2];
    logic signed [DW-1:0] dov6_reg [2];
    logic signed [DW-1:0] dx6_reg  [2];
    logic signed [DW-1:0] dy6_reg  [2];
    logic [1:0]           opos6_reg;
    logic [1:0]           strad6_reg;

    always_comb
    begin
        aval[0][0] = '0;
        for (int i = 1; i < 3; i++)
        begin
            aval[0][i] = AW'(apr_reg[i-1][0]) + AW'(apr_reg[i-1][1]) + AW'(apr_reg[i-1][2]);
        end
        for (int i = 0; i < 3; i++)
        begin
            aval[1][i] = AW'(bpr_reg[i][0]) + AW'(bpr_reg[i][1]) + AW'(bpr_reg[i][2]);
        end
        for (int t = 0; t < 2; t++)
        begin
            xsel[t] = (osel5_reg[t] == 2'd0) ? 2'd1 : 2'd0;
            ysel[t] = (osel5_reg[t] == 2'd2) ? 2'd1 : 2'd2;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < 2; t++)
        begin
            ao6_reg[t]  <= aval[t][osel5_reg[t]];
            ax6_reg[t]  <= aval[t][xsel[t]];
            ay6_reg[t]  <= aval[t][ysel[t]];
            dov6_reg[t] <= dd5_reg[t][osel5_reg[t]];
            dx6_reg[t]  <= dd5_reg[t][xsel[t]];
            dy6_reg[t]  <= dd5_reg[t][ysel[t]];
        end
        opos6_reg  <= opos5_reg;
        strad6_reg <= strad5_reg;
    end

    // end point products
    logic signed [P1W-1:0] m1_p [2][4];

    for (genvar t = 0; t < 2; t++) begin : g_bank1
        tpi_mul #(.WA(AW), .WB(DW)) u_m0 (
            .clk (clk),
            .a   (ao6_reg[t]),
            .b   (dx6_reg[t]),
            .p   (m1_p[t][0])
        );
        tpi_mul #(.WA(AW), .WB(DW)) u_m1 (
            .clk (clk),
            .a   (ax6_reg[t]),
            .b   (dov6_reg[t]),
            .p   (m1_p[t][1])
        );
        tpi_mul #(.WA(AW), .WB(DW)) u_m2 (
            .clk (clk),
            .a   (ao6_reg[t]),
            .b   (dy6_reg[t]),
            .p   (m1_p[t][2])
        );
        tpi_mul #(.WA(AW), .WB(DW)) u_m3 (
            .clk (clk),
            .a   (ay6_reg[t]),
            .b   (dov6_reg[t]),
            .p   (m1_p[t][3])
        );
    end

    logic [B1W-1:0]       dl1_reg [L1];
    logic [B1W-1:0]       dl1_tail;
    logic signed [DW-1:0] dov_d [2];
    logic signed [DW-1:0] dx_d  [2];
    logic signed [DW-1:0] dy_d  [2];
    logic [1:0]           opos_d;
    logic [1:0]           strad_d;

    always_ff @(posedge clk)
    begin
        dl1_reg[0] <= {dov6_reg[0], dx6_reg[0], dy6_reg[0],
                       dov6_reg[1], dx6_reg[1], dy6_reg[1], opos6_reg, strad6_reg};
        for (int k = 1; k < L1; k++)
        begin
            dl1_reg[k] <= dl1_reg[k-1];
        end
    end

    assign dl1_tail = dl1_reg[L1-1];
    assign strad_d  = dl1_tail[1:0];
    assign opos_d   = dl1_tail[3:2];
    assign dy_d[1]  = dl1_tail[4        +: DW];
    assign dx_d[1]  = dl1_tail[4 + DW   +: DW];
    assign dov_d[1] = dl1_tail[4 + 2*DW +: DW];
    assign dy_d[0]  = dl1_tail[4 + 3*DW +: DW];
    assign dx_d[0]  = dl1_tail[4 + 4*DW +: DW];
    assign dov_d[0] = dl1_tail[4 + 5*DW +: DW];

    // stage 7: end points as num/den with den > 0
    logic signed [NUMW-1:0] nm_reg [2][2];
    logic signed [DENW-1:0] dn_reg [2][2];
    logic [1:0]             strad7_reg;

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < 2; t++)
        begin
            if (opos_d[t])
            begin
                nm_reg[t][0] <= NUMW'(m1_p[t][1]) - NUMW'(m1_p[t][0]);
                nm_reg[t][1] <= NUMW'(m1_p[t][3]) - NUMW'(m1_p[t][2]);
                dn_reg[t][0] <= DENW'(dov_d[t]) - DENW'(dx_d[t]);
                dn_reg[t][1] <= DENW'(dov_d[t]) - DENW'(dy_d[t]);
            end
            else
            begin
                nm_reg[t][0] <= NUMW'(m1_p[t][0]) - NUMW'(m1_p[t][1]);
                nm_reg[t][1] <= NUMW'(m1_p[t][2]) - NUMW'(m1_p[t][3]);
                dn_reg[t][0] <= DENW'(dx_d[t]) - DENW'(dov_d[t]);
                dn_reg[t][1] <= DENW'(dy_d[t]) - DENW'(dov_d[t]);
            end
        end
        strad7_reg <= strad_d;
    end

    // cross products for end point compares
    logic signed [PRW-1:0] c1_p [2][2];
    logic signed [PRW-1:0] c2_p [2][2];

    for (genvar i = 0; i < 2; i++) begin : g_bank2_i
        for (genvar j = 0; j < 2; j++) begin : g_bank2_j
            tpi_mul #(.WA(NUMW), .WB(DENW)) u_c1 (
                .clk (clk),
                .a   (nm_reg[0][i]),
                .b   (dn_reg[1][j]),
                .p   (c1_p[i][j])
            );
            tpi_mul #(.WA(NUMW), .WB(DENW)) u_c2 (
                .clk (clk),
                .a   (nm_reg[1][j]),
                .b   (dn_reg[0][i]),
                .p   (c2_p[i][j])
            );
        end
    end

    logic [1:0] dl2_reg [L2];

    always_ff @(posedge clk)
    begin
        dl2_reg[0] <= strad7_reg;
        for (int k = 1; k < L2; k++)
        begin
            dl2_reg[k] <= dl2_reg[k-1];
        end
    end

    // stage 8: strict overlap
    logic any_gt;
    logic any_lt;
    logic hit_reg;
    logic sa_reg;
    logic sb_reg;

    always_comb
    begin
        any_gt = 1'b0;
        any_lt = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                any_gt = any_gt | (c1_p[i][j] > c2_p[i][j]);
                any_lt = any_lt | (c1_p[i][j] < c2_p[i][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= (&dl2_reg[L2-1]) && any_gt && any_lt;
        sa_reg  <= dl2_reg[L2-1][0];
        sb_reg  <= dl2_reg[L2-1][1];
    end

    assign done                = vld_reg[LAT-1];
    assign hit                 = hit_reg;
    assign a_straddles_b_plane = sa_reg;
    assign b_straddles_a_plane = sb_reg;

    // every beat comes back after a fixed latency
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("beat accepted without result after pipeline latency");

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result strobe without matching accepted beat");

    a_hit_needs_straddle: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> a_straddles_b_plane && b_straddles_a_plane)
        else $error("hit reported without both straddles");

endmodule

`default_nettype wire
